/* rtl/oht_pkg.sv */
// shared types, register indexes and constants for the orientation health tracker
`default_nettype none

package oht_pkg;

    // one full turn in 1/16 degree
    localparam int unsigned FULL_TURN     = 5760;
    localparam int unsigned TIME_BITS_DEF = 32;

    localparam int unsigned ANGLE_W   = 13;
    localparam int unsigned ROLL_W    = 12;
    localparam int unsigned PITCH_W   = 14;
    localparam int unsigned SCORE_W   = 2;
    localparam int unsigned RATE_W    = 16;
    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    // stream word widths, padded to whole bytes
    localparam int unsigned S_FIELDS_W = 126;
    localparam int unsigned S_TDATA_W  = 128;
    localparam int unsigned M_FIELDS_W = 49;
    localparam int unsigned M_TDATA_W  = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENSOR_READY  = 3'd0,
        REG_MIN_SYS_SCORE = 3'd1,
        REG_MIN_MAG_SCORE = 3'd2,
        REG_DECLINATION   = 3'd3,
        REG_HEADING_TRIM  = 3'd4,
        REG_PITCH_TRIM    = 3'd5,
        REG_STILL_LIMIT   = 3'd6,
        REG_GRACE_MS      = 3'd7
    } oht_reg_idx_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DEGRADED = 2'd1,
        STATUS_FAIL     = 2'd2
    } oht_status_t;

    typedef struct packed {
        logic                       sensor_ready;
        logic [SCORE_W-1:0]         min_system_score;
        logic [SCORE_W-1:0]         min_magnet_score;
        logic signed [ANGLE_W-1:0]  declination;
        logic signed [ANGLE_W-1:0]  heading_trim;
        logic signed [ANGLE_W-1:0]  pitch_trim;
        logic [CFG_DAT_W-1:0]       still_limit_sq;
        logic [CFG_DAT_W-1:0]       grace_ms;
    } oht_cfg_t;

    // control from the register file to the health monitor
    typedef struct packed {
        logic clear_health;
    } oht_cfg_ctl_t;

endpackage

`default_nettype wire

/* rtl/oht_cfg_regs.sv */
// configuration register file with health clear on a ready write
`default_nettype none

module oht_cfg_regs
    import oht_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,
    output oht_cfg_t                   cfg,
    output oht_cfg_ctl_t               ctl
);

    oht_cfg_t cfg_reg;
    oht_cfg_t cfg_next;
    logic     clear_next;

    always_comb begin
        cfg_next   = cfg_reg;
        clear_next = 1'b0;
        if (cfg_we) begin
            case (oht_reg_idx_t'(cfg_index))
                REG_SENSOR_READY: begin
                    cfg_next.sensor_ready = cfg_wdata[0];
                    clear_next            = 1'b1;
                end
                REG_MIN_SYS_SCORE: cfg_next.min_system_score = cfg_wdata[SCORE_W-1:0];
                REG_MIN_MAG_SCORE: cfg_next.min_magnet_score = cfg_wdata[SCORE_W-1:0];
                REG_DECLINATION:   cfg_next.declination  = $signed(cfg_wdata[ANGLE_W-1:0]);
                REG_HEADING_TRIM:  cfg_next.heading_trim = $signed(cfg_wdata[ANGLE_W-1:0]);
                REG_PITCH_TRIM:    cfg_next.pitch_trim   = $signed(cfg_wdata[ANGLE_W-1:0]);
                REG_STILL_LIMIT:   cfg_next.still_limit_sq = cfg_wdata;
                REG_GRACE_MS:      cfg_next.grace_ms       = cfg_wdata;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensor_ready     <= 1'b0;
            cfg_reg.min_system_score <= 2'd3;
            cfg_reg.min_magnet_score <= 2'd3;
            cfg_reg.declination      <= '0;
            cfg_reg.heading_trim     <= '0;
            cfg_reg.pitch_trim       <= '0;
            cfg_reg.still_limit_sq   <= '0;
            cfg_reg.grace_ms         <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg              = cfg_reg;
    assign ctl.clear_health = clear_next;

endmodule

`default_nettype wire

/* rtl/oht_angle_corr.sv */
// heading correction with wrap into one turn, and pitch trim
`default_nettype none

module oht_angle_corr
    import oht_pkg::*;
(
    input  wire logic [ANGLE_W-1:0]         heading_raw,
    input  wire logic signed [ANGLE_W-1:0]  pitch_raw,
    input  wire logic signed [ANGLE_W-1:0]  declination,
    input  wire logic signed [ANGLE_W-1:0]  heading_trim,
    input  wire logic signed [ANGLE_W-1:0]  pitch_trim,
    output logic [ANGLE_W-1:0]              heading,
    output logic signed [PITCH_W-1:0]       pitch
);

    localparam int unsigned SUM_W = 16;
    // bias of two turns lifts the lowest possible sum above zero
    localparam logic [SUM_W-1:0] BIAS  = SUM_W'(2 * FULL_TURN);
    localparam logic [SUM_W-1:0] TURN1 = SUM_W'(FULL_TURN);
    localparam logic [SUM_W-1:0] TURN2 = SUM_W'(2 * FULL_TURN);
    localparam logic [SUM_W-1:0] TURN3 = SUM_W'(3 * FULL_TURN);
    localparam logic [SUM_W-1:0] TURN4 = SUM_W'(4 * FULL_TURN);

    logic signed [SUM_W-1:0] sum_s;
    logic [SUM_W-1:0]        biased;
    logic [SUM_W-1:0]        wrapped;

    always_comb begin
        sum_s  = $signed({{(SUM_W-ANGLE_W){1'b0}}, heading_raw})
               + SUM_W'(declination) + SUM_W'(heading_trim);
        biased = $unsigned(sum_s) + BIAS;
        // parallel compares pick the number of turns to remove
        if (biased >= TURN4) begin
            wrapped = biased - TURN4;
        end else if (biased >= TURN3) begin
            wrapped = biased - TURN3;
        end else if (biased >= TURN2) begin
            wrapped = biased - TURN2;
        end else if (biased >= TURN1) begin
            wrapped = biased - TURN1;
        end else begin
            wrapped = biased;
        end
        heading = wrapped[ANGLE_W-1:0];
        pitch   = PITCH_W'(pitch_raw) + PITCH_W'(pitch_trim);
    end

endmodule

`default_nettype wire

/* rtl/oht_health_mon.sv */
// stillness test on the gyro magnitude and calibration health state
`default_nettype none

module oht_health_mon
    import oht_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  oht_cfg_t                       cfg,
    input  oht_cfg_ctl_t                   ctl,
    input  wire logic                      step_en,
    input  wire logic [SCORE_W-1:0]        system_score,
    input  wire logic [SCORE_W-1:0]        magnet_score,
    input  wire logic signed [RATE_W-1:0]  rate_x,
    input  wire logic signed [RATE_W-1:0]  rate_y,
    input  wire logic signed [RATE_W-1:0]  rate_z,
    input  wire logic [STAMP_W-1:0]        now_ms,
    output logic                           healthy_next
);

    localparam int unsigned CMP_W = (TIME_BITS > CFG_DAT_W) ? TIME_BITS : CFG_DAT_W;
    localparam int unsigned SQ_W  = 2 * RATE_W;

    logic                 healthy_reg;
    logic                 armed_reg, armed_next;
    logic [TIME_BITS-1:0] since_reg, since_next;

    logic signed [SQ_W-1:0] sq_x, sq_y, sq_z;
    logic [SQ_W-1:0]        mag_sq;
    logic                   still;
    logic                   good;
    logic [CMP_W-1:0]       now_wide;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   elapsed;
    logic                   grace_over;

    always_comb begin
        sq_x   = rate_x * rate_x;
        sq_y   = rate_y * rate_y;
        sq_z   = rate_z * rate_z;
        // squares are never negative and the sum stays below 2^32
        mag_sq = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
        still  = (mag_sq <= cfg.still_limit_sq);
        good   = (system_score >= cfg.min_system_score)
              && (magnet_score >= cfg.min_magnet_score);

        now_wide   = CMP_W'(now_ms);
        now_t      = now_wide[TIME_BITS-1:0];
        elapsed    = now_t - since_reg;
        grace_over = (CMP_W'(elapsed) >= CMP_W'(cfg.grace_ms));

        healthy_next = healthy_reg;
        armed_next   = armed_reg;
        since_next   = since_reg;
        if (good) begin
            healthy_next = 1'b1;
            armed_next   = 1'b0;
            since_next   = '0;
        end else if (healthy_reg && still) begin
            armed_next = 1'b0;
            since_next = '0;
        end else if (healthy_reg) begin
            if (!armed_reg) begin
                armed_next = 1'b1;
                since_next = now_t;
            end else if (grace_over) begin
                healthy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear_health) begin
            healthy_reg <= 1'b0;
            armed_reg   <= 1'b0;
            since_reg   <= '0;
        end else if (step_en) begin
            healthy_reg <= healthy_next;
            armed_reg   <= armed_next;
            since_reg   <= since_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/imu_orientation_health_tracker_unit.sv */
// top level of the orientation health tracker: stream ports, pipeline and result register
//
// usage
//   slave stream (s_*) takes one orientation sample per word; master stream (m_*) gives
//   one corrected result word per sample, in order. a word moves when tvalid and tready
//   are both high at a rising edge of aclk.
//   configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write only while
//   the block is idle. any write to sensor_ready clears the health state.
// pipeline and throughput
//   an accepted word sits in the input register; the angle correction, gyro squares
//   and health update then feed the result register, which drives m_*. one word per
//   cycle sustained while m_tready stays high; the health flag loop closes within the
//   result stage.
// reset
//   aresetn is synchronous, active low; both stages empty, registers take their reset
//   values (sensor not ready, so results report fail), health state cleared.
// stall
//   when m_tready is low the result is held; the input register still takes one more
//   word while empty, after which s_tready drops until the result is taken.
`default_nettype none

module imu_orientation_health_tracker_unit
    import oht_pkg::*;
#(
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // heading_raw, roll_raw, pitch_raw, system_score, gyro_score, accel_score,
    // magnet_score, rate_x, rate_y, rate_z, now_ms, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // heading, roll, pitch, system_score_out, gyro_score_out, accel_score_out,
    // magnet_score_out, status, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata
);

    oht_cfg_t     cfg;
    oht_cfg_ctl_t cfg_ctl;

    // input stage
    logic                  in_valid_reg;
    logic [S_FIELDS_W-1:0] in_data_reg;

    // result stage
    logic                  out_valid_reg;
    logic [M_FIELDS_W-1:0] out_data_reg;
    logic [M_FIELDS_W-1:0] out_data_next;

    logic out_free;
    logic in_move;
    logic step_en;

    // fields of the held sample
    logic [ANGLE_W-1:0]         heading_raw;
    logic signed [ROLL_W-1:0]   roll_raw;
    logic signed [ANGLE_W-1:0]  pitch_raw;
    logic [SCORE_W-1:0]         system_score;
    logic [SCORE_W-1:0]         gyro_score;
    logic [SCORE_W-1:0]         accel_score;
    logic [SCORE_W-1:0]         magnet_score;
    logic signed [RATE_W-1:0]   rate_x;
    logic signed [RATE_W-1:0]   rate_y;
    logic signed [RATE_W-1:0]   rate_z;
    logic [STAMP_W-1:0]         now_ms;

    logic [ANGLE_W-1:0]         heading;
    logic signed [PITCH_W-1:0]  pitch;
    logic                       healthy_next;
    oht_status_t                status;

    assign heading_raw  = in_data_reg[12:0];
    assign roll_raw     = $signed(in_data_reg[24:13]);
    assign pitch_raw    = $signed(in_data_reg[37:25]);
    assign system_score = in_data_reg[39:38];
    assign gyro_score   = in_data_reg[41:40];
    assign accel_score  = in_data_reg[43:42];
    assign magnet_score = in_data_reg[45:44];
    assign rate_x       = $signed(in_data_reg[61:46]);
    assign rate_y       = $signed(in_data_reg[77:62]);
    assign rate_z       = $signed(in_data_reg[93:78]);
    assign now_ms       = in_data_reg[125:94];

    // handshake: result register frees when taken, input register moves into it
    assign out_free = !out_valid_reg || m_tready;
    assign in_move  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    // health state only advances on samples seen while the sensor is ready
    assign step_en  = in_move && cfg.sensor_ready;

    oht_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .ctl       (cfg_ctl)
    );

    oht_angle_corr u_angle_corr (
        .heading_raw  (heading_raw),
        .pitch_raw    (pitch_raw),
        .declination  (cfg.declination),
        .heading_trim (cfg.heading_trim),
        .pitch_trim   (cfg.pitch_trim),
        .heading      (heading),
        .pitch        (pitch)
    );

    oht_health_mon #(
        .TIME_BITS (TIME_BITS)
    ) u_health_mon (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .ctl          (cfg_ctl),
        .step_en      (step_en),
        .system_score (system_score),
        .magnet_score (magnet_score),
        .rate_x       (rate_x),
        .rate_y       (rate_y),
        .rate_z       (rate_z),
        .now_ms       (now_ms),
        .healthy_next (healthy_next)
    );

    // status reflects the flag after this sample's update
    always_comb begin
        status = healthy_next ? STATUS_OK : STATUS_DEGRADED;
        if (!cfg.sensor_ready) begin
            // not ready: every field zero apart from a fail status
            out_data_next        = '0;
            out_data_next[48:47] = STATUS_FAIL;
        end else begin
            out_data_next = {status, magnet_score, accel_score, gyro_score, system_score,
                             pitch, roll_raw, heading};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers need no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[S_FIELDS_W-1:0];
        end
        if (in_move) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire
